### hw/rtl/vertex_weld_remap_assert.svh
// ----------------------------------------------------------------------------
// Vertex weld remap assertion macros
// Shared concurrent assertion forms for the vertex weld remap checkers.
// ----------------------------------------------------------------------------
`ifndef VERTEX_WELD_REMAP_ASSERT_SVH
`define VERTEX_WELD_REMAP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VWR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VWR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/vwr_pkg.sv
// ----------------------------------------------------------------------------
// Vertex weld remap package
// Fixed field widths, command and status codes shared by the block.
// ----------------------------------------------------------------------------
package vwr_pkg;

    // Fixed widths of the external fields.
    localparam int EPS_W       = 52;
    localparam int FIELD_IDX_W = 10;
    localparam int STATUS_W    = 2;
    localparam int RES_W       = FIELD_IDX_W + STATUS_W;

    // Meaning of the action field.
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_REMAP = 1'b1;

    // Commands handed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_ADD,
        OP_REMAP,
        OP_FULL,
        OP_UNLOADED
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_UNLOADED = 2'd2
    } status_t;

    // Status of the distance pipeline as seen by the scan controller.
    typedef struct packed {
        logic hit;
        logic busy;
    } dist_stat_t;

endpackage

### hw/rtl/vertex_weld_remap.sv
// ----------------------------------------------------------------------------
// Vertex weld remap
// Welds incoming vertices to earlier close ones and remaps corner indices.
// ----------------------------------------------------------------------------
// Input words enter through push/full: action 0 adds the vertex on coord_x,
// coord_y and coord_z, action 1 asks for the representative of query_index.
// Results leave through empty/pop in input order; the oldest word sits on
// rep_index and status while empty is low and leaves when pop is high.
// The user must write the weld threshold eps_squared on cfg_valid/cfg_ready/
// cfg_data (ready is always high) only while the block is idle; the block
// itself does not enforce this. An add with n vertices already stored scans
// them one per cycle from the single read port of the vertex store and stops
// at the first match. The engine runs one word at a time and takes the next
// one only after it hands a result to the output queue.
// Two-word queues sit before and after the execution engine, so input is
// still taken while results wait. A stalled receiver fills the result
// queue, then the command queue, and then full rises.
// Reset empties both queues, clears the vertex count and sets the threshold
// to zero; stored vertices are not cleared, and none can be read before it
// is written.
// ----------------------------------------------------------------------------
module vertex_weld_remap #(
    parameter int MAX_VERTS  = 1024,
    parameter int COORD_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            action,
    input  logic [COORD_BITS-1:0]           coord_x,
    input  logic [COORD_BITS-1:0]           coord_y,
    input  logic [COORD_BITS-1:0]           coord_z,
    input  logic [vwr_pkg::FIELD_IDX_W-1:0] query_index,
    output logic                            empty,
    input  logic                            pop,
    output logic [vwr_pkg::FIELD_IDX_W-1:0] rep_index,
    output logic [vwr_pkg::STATUS_W-1:0]    status,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vwr_pkg::EPS_W-1:0]       cfg_data
);

    import vwr_pkg::*;

    localparam int IDX_W     = $clog2(MAX_VERTS);
    localparam int CMD_W     = 2 + 3 * COORD_BITS + IDX_W;
    localparam int Q_DEPTH   = 2;

    logic [EPS_W-1:0] eps_reg;
    logic             cmd_push;
    logic             cmd_full;
    logic [CMD_W-1:0] cmd_wdata;
    logic             cmd_pop;
    logic             cmd_empty;
    logic [CMD_W-1:0] cmd_rdata;
    logic             res_push;
    logic             res_full;
    logic [RES_W-1:0] res_wdata;
    logic [RES_W-1:0] res_rdata;

    // Threshold register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            eps_reg <= cfg_data;
        end
    end

    vwr_front #(
        .MAX_VERTS  (MAX_VERTS),
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .query_index (query_index),
        .cmd_push    (cmd_push),
        .cmd_full    (cmd_full),
        .cmd_data    (cmd_wdata)
    );

    vwr_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (Q_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .full  (cmd_full),
        .wdata (cmd_wdata),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .rdata (cmd_rdata)
    );

    vwr_back #(
        .MAX_VERTS  (MAX_VERTS),
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .eps       (eps_reg),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd_data  (cmd_rdata),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_wdata)
    );

    vwr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (Q_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (res_wdata),
        .pop   (pop),
        .empty (empty),
        .rdata (res_rdata)
    );

    // Result word fields.
    assign rep_index = res_rdata[RES_W-1 -: FIELD_IDX_W];
    assign status    = res_rdata[STATUS_W-1:0];

endmodule

### hw/rtl/vwr_fifo.sv
// ----------------------------------------------------------------------------
// Vertex weld remap queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module vwr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Word storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### hw/rtl/vwr_front.sv
// ----------------------------------------------------------------------------
// Vertex weld remap front end
// Accepts input words, tracks the vertex count and classifies each word.
// ----------------------------------------------------------------------------
module vwr_front #(
    parameter int MAX_VERTS  = 1024,
    parameter int COORD_BITS = 24,
    parameter int CMD_W      = 2 + 3 * COORD_BITS + $clog2(MAX_VERTS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          action,
    input  logic [COORD_BITS-1:0]         coord_x,
    input  logic [COORD_BITS-1:0]         coord_y,
    input  logic [COORD_BITS-1:0]         coord_z,
    input  logic [vwr_pkg::FIELD_IDX_W-1:0] query_index,
    output logic                          cmd_push,
    input  logic                          cmd_full,
    output logic [CMD_W-1:0]              cmd_data
);

    import vwr_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTS);
    localparam int CNT_W = $clog2(MAX_VERTS + 1);
    localparam int CMP_W = (CNT_W > FIELD_IDX_W) ? CNT_W : FIELD_IDX_W;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             accept;
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [CMP_W-1:0] q_ext;
    logic [CMP_W-1:0] cnt_ext;

    assign full     = cmd_full;
    assign accept   = push & ~cmd_full;
    assign cmd_push = accept;
    assign cmd_data = {op, coord_z, coord_y, coord_x, idx};

    // Classify the word against the count of vertices already committed
    // or queued ahead of it.
    always_comb
    begin
        q_ext      = CMP_W'(query_index);
        cnt_ext    = CMP_W'(count_reg);
        count_next = count_reg;
        op         = OP_ADD;
        idx        = count_reg[IDX_W-1:0];
        if (action == ACT_ADD)
        begin
            if (count_reg == CNT_W'(MAX_VERTS))
            begin
                op = OP_FULL;
            end
            else if (accept)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            idx = q_ext[IDX_W-1:0];
            op  = (q_ext >= cnt_ext) ? OP_UNLOADED : OP_REMAP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

### hw/rtl/vwr_dist.sv
// ----------------------------------------------------------------------------
// Vertex weld remap distance pipeline
// Squared distance between the new vertex and one stored vertex per cycle.
// ----------------------------------------------------------------------------
module vwr_dist #(
    parameter int COORD_BITS = 24,
    parameter int IDX_W      = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [IDX_W-1:0]          in_idx,
    input  logic [COORD_BITS-1:0]     qx,
    input  logic [COORD_BITS-1:0]     qy,
    input  logic [COORD_BITS-1:0]     qz,
    input  logic [COORD_BITS-1:0]     sx,
    input  logic [COORD_BITS-1:0]     sy,
    input  logic [COORD_BITS-1:0]     sz,
    input  logic [vwr_pkg::EPS_W-1:0] eps,
    output vwr_pkg::dist_stat_t       stat,
    output logic [IDX_W-1:0]          hit_idx
);

    import vwr_pkg::*;

    localparam int AD_W  = COORD_BITS + 1;
    localparam int SQ_W  = 2 * AD_W;
    localparam int PS_W  = SQ_W + 1;
    localparam int D_W   = SQ_W + 2;
    localparam int CMP_W = (D_W > EPS_W) ? D_W : EPS_W;

    // Magnitude of the difference of two signed coordinates.
    function automatic logic [AD_W-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic signed [AD_W-1:0] d;
        d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
        return d[AD_W-1] ? AD_W'(-d) : AD_W'(d);
    endfunction

    logic             v2_reg, v3_reg, v4_reg;
    logic [IDX_W-1:0] i2_reg, i3_reg, i4_reg;
    logic [AD_W-1:0]  adx_reg, ady_reg, adz_reg;
    logic [SQ_W-1:0]  sqx_reg, sqy_reg, sqz_reg, sqz4_reg;
    logic [PS_W-1:0]  psum_reg;
    logic [D_W-1:0]   d2;
    logic             hit;

    // Final add and threshold compare; status packs hit above busy.
    assign d2        = D_W'(psum_reg) + D_W'(sqz4_reg);
    assign hit       = v4_reg & (CMP_W'(d2) < CMP_W'(eps));
    assign stat      = {hit, v2_reg | v3_reg | v4_reg};
    assign hit_idx   = i4_reg;

    // Valid bits; a hit drops everything younger than the matching entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= in_valid & ~hit;
            v3_reg <= v2_reg & ~hit;
            v4_reg <= v3_reg & ~hit;
        end
    end

    // Datapath: differences, squares, partial sum.
    always_ff @(posedge clk)
    begin
        i2_reg   <= in_idx;
        adx_reg  <= abs_diff(qx, sx);
        ady_reg  <= abs_diff(qy, sy);
        adz_reg  <= abs_diff(qz, sz);
        i3_reg   <= i2_reg;
        sqx_reg  <= adx_reg * adx_reg;
        sqy_reg  <= ady_reg * ady_reg;
        sqz_reg  <= adz_reg * adz_reg;
        i4_reg   <= i3_reg;
        psum_reg <= PS_W'(sqx_reg) + PS_W'(sqy_reg);
        sqz4_reg <= sqz_reg;
    end

endmodule

### hw/rtl/vwr_back.sv
// ----------------------------------------------------------------------------
// Vertex weld remap back end
// Runs commands in order: scans the vertex store, commits, remaps and reports full or unloaded.
// ----------------------------------------------------------------------------
module vwr_back #(
    parameter int MAX_VERTS  = 1024,
    parameter int COORD_BITS = 24,
    parameter int CMD_W      = 2 + 3 * COORD_BITS + $clog2(MAX_VERTS)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [vwr_pkg::EPS_W-1:0] eps,
    input  logic                      cmd_empty,
    output logic                      cmd_pop,
    input  logic [CMD_W-1:0]          cmd_data,
    input  logic                      res_full,
    output logic                      res_push,
    output logic [vwr_pkg::RES_W-1:0] res_data
);

    import vwr_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTS);
    localparam int CNT_W = $clog2(MAX_VERTS + 1);
    localparam int RW    = (IDX_W > FIELD_IDX_W) ? IDX_W : FIELD_IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REMAP,
        S_COMMIT
    } state_t;

    state_t                  state_reg;
    logic [COORD_BITS-1:0]   qx_reg, qy_reg, qz_reg;
    logic [IDX_W-1:0]        own_reg;
    logic [IDX_W-1:0]        best_reg;
    logic [CNT_W-1:0]        k_reg;
    logic                    rd_valid_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic [3*COORD_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]        rep_rd_reg;
    logic                    res_push_reg;
    logic [FIELD_IDX_W-1:0]  res_rep_reg;
    status_t                 res_status_reg;

    logic [3*COORD_BITS-1:0] store_mem [MAX_VERTS];
    logic [IDX_W-1:0]        rep_mem [MAX_VERTS];

    op_t                     cmd_op;
    logic [IDX_W-1:0]        cmd_idx;
    logic [COORD_BITS-1:0]   cmd_x, cmd_y, cmd_z;
    logic                    issue;
    logic                    scan_done;
    logic                    store_we;
    dist_stat_t              dstat;
    logic [IDX_W-1:0]        hit_idx;
    logic [RW-1:0]           best_ext;
    logic [RW-1:0]           own_ext;
    logic [RW-1:0]           rep_ext;

    // Command word fields.
    assign cmd_op  = op_t'(cmd_data[CMD_W-1 -: 2]);
    assign cmd_idx = cmd_data[IDX_W-1:0];
    assign cmd_x   = cmd_data[IDX_W +: COORD_BITS];
    assign cmd_y   = cmd_data[IDX_W + COORD_BITS +: COORD_BITS];
    assign cmd_z   = cmd_data[IDX_W + 2 * COORD_BITS +: COORD_BITS];

    // Take a command only when the result queue is sure to have room.
    assign cmd_pop   = (state_reg == S_IDLE) && !cmd_empty && !res_full && !res_push_reg;
    assign issue     = (state_reg == S_SCAN) && !dstat.hit && (k_reg < CNT_W'(own_reg));
    assign scan_done = (state_reg == S_SCAN) && !dstat.hit && !issue && !rd_valid_reg
                       && !dstat.busy;
    assign store_we  = (state_reg == S_COMMIT);

    // Representative widened or cut to the result field.
    assign best_ext = RW'(best_reg);
    assign own_ext  = RW'(own_reg);
    assign rep_ext  = RW'(rep_rd_reg);

    assign res_push = res_push_reg;
    assign res_data = {res_rep_reg, res_status_reg};

    vwr_dist #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_valid_reg),
        .in_idx   (rd_idx_reg),
        .qx       (qx_reg),
        .qy       (qy_reg),
        .qz       (qz_reg),
        .sx       (rd_data_reg[0 +: COORD_BITS]),
        .sy       (rd_data_reg[COORD_BITS +: COORD_BITS]),
        .sz       (rd_data_reg[2 * COORD_BITS +: COORD_BITS]),
        .eps      (eps),
        .stat     (dstat),
        .hit_idx  (hit_idx)
    );

    // Sequencer: state, scan counter and the registered result word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            k_reg          <= '0;
            rd_valid_reg   <= 1'b0;
            res_push_reg   <= 1'b0;
            res_rep_reg    <= '0;
            res_status_reg <= ST_OK;
        end
        else
        begin
            res_push_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_pop)
                    begin
                        unique case (cmd_op)
                            OP_ADD:
                            begin
                                k_reg     <= '0;
                                state_reg <= S_SCAN;
                            end
                            OP_REMAP:
                            begin
                                state_reg <= S_REMAP;
                            end
                            OP_FULL:
                            begin
                                res_push_reg   <= 1'b1;
                                res_rep_reg    <= '0;
                                res_status_reg <= ST_FULL;
                            end
                            OP_UNLOADED:
                            begin
                                res_push_reg   <= 1'b1;
                                res_rep_reg    <= '0;
                                res_status_reg <= ST_UNLOADED;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    rd_valid_reg <= issue;
                    if (issue)
                    begin
                        k_reg <= k_reg + CNT_W'(1);
                    end
                    if (dstat.hit || scan_done)
                    begin
                        state_reg <= S_COMMIT;
                    end
                end
                S_REMAP:
                begin
                    res_push_reg   <= 1'b1;
                    res_rep_reg    <= rep_ext[FIELD_IDX_W-1:0];
                    res_status_reg <= ST_OK;
                    state_reg      <= S_IDLE;
                end
                S_COMMIT:
                begin
                    res_push_reg   <= 1'b1;
                    res_rep_reg    <= best_ext[FIELD_IDX_W-1:0];
                    res_status_reg <= ST_OK;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload held for the command in flight.
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            qx_reg  <= cmd_x;
            qy_reg  <= cmd_y;
            qz_reg  <= cmd_z;
            own_reg <= cmd_idx;
        end
        if (dstat.hit)
        begin
            best_reg <= hit_idx;
        end
        else if (scan_done)
        begin
            best_reg <= own_ext[IDX_W-1:0];
        end
        rd_idx_reg <= k_reg[IDX_W-1:0];
    end

    // Vertex store: one write at commit, one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[own_reg] <= {qz_reg, qy_reg, qx_reg};
        end
        rd_data_reg <= store_mem[k_reg[IDX_W-1:0]];
    end

    // Representative map: written at commit, read for a remap.
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            rep_mem[own_reg] <= best_reg;
        end
        rep_rd_reg <= rep_mem[cmd_idx];
    end

endmodule

### hw/rtl/vwr_checker.sv
// ----------------------------------------------------------------------------
// Vertex weld remap checker
// Port-level assertions on the result and input queues, bound to the top.
// ----------------------------------------------------------------------------
`include "vertex_weld_remap_assert.svh"

module vwr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            push,
    input logic                            full,
    input logic                            empty,
    input logic                            pop,
    input logic [vwr_pkg::FIELD_IDX_W-1:0] rep_index,
    input logic [vwr_pkg::STATUS_W-1:0]    status
);

    import vwr_pkg::*;

    // An error result carries no representative.
    `VWR_ASSERT_IMPL(a_err_rep_zero, clk, rst_n, !empty && (status != ST_OK), rep_index == '0, "error word with nonzero rep_index")

    // A waiting result word holds until it is popped.
    `VWR_ASSERT_NEXT(a_res_hold, clk, rst_n, !empty && !pop, !empty && $stable(rep_index) && $stable(status), "result word changed before pop")

    // The input side only fills through an accepted word.
    `VWR_ASSERT_IMPL(a_full_cause, clk, rst_n, $rose(full), $past(push && !full), "full rose without an accepted word")

endmodule

bind vertex_weld_remap vwr_checker u_vwr_checker (.*);
